// File: sv/utf8_stream_decoder_assert.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define UTF8D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utf8 decoder assertion failed");
`define UTF8D_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("utf8 decoder assertion failed");
`else
`define UTF8D_ASSERT(lbl, clk, rst, prop)
`define UTF8D_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/utf8d_pkg.sv
// Types and constants shared by the UTF-8 stream decoder modules.
package utf8d_pkg;

   localparam int CP_W  = 21;
   localparam int ST_W  = 3;
   localparam int CNT_W = 3;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0] SURR_LOW    = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HIGH   = 21'h00DFFF;
   localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;

   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_LEAD  = 3'd1;
   localparam logic [ST_W-1:0] ST_TRAIL = 3'd2;
   localparam logic [ST_W-1:0] ST_CP    = 3'd3;
   localparam logic [ST_W-1:0] ST_TRUNC = 3'd4;

   typedef struct packed {
      logic              last_result;
      logic [CNT_W-1:0]  byte_count;
      logic [ST_W-1:0]   status;
      logic [CP_W-1:0]   code_point;
   } result_type;

   // All results caused by one input byte travel together through the queue.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   function automatic logic scalar_ok(input logic [CP_W-1:0] v);
      return (v < SURR_LOW) || ((v > SURR_HIGH) && (v <= MAX_SCALAR));
   endfunction

endpackage

// File: sv/utf8d_front.sv
// Front end: byte-level UTF-8 sequence tracking and result generation.
module utf8d_front
   import utf8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_in,
   input  logic       end_of_buffer,
   output logic       push,
   output entry_type  entry
);

`include "utf8_stream_decoder_assert.svh"

   logic [CP_W-1:0]  acc_ff, acc_in;
   logic [1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] len_ff, len_in;

   logic             lead_has_res;
   result_type       lead_res;
   logic [CNT_W-1:0] lead_len;
   logic [CP_W-1:0]  lead_bits;
   logic [CNT_W-1:0] consumed;
   logic [CP_W-1:0]  acc_next;

   // Decode of the byte as a lead, independent of the current state.
   always_comb begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, byte_in[2:0]};
      if (byte_in[7:5] == 3'b110) begin
         lead_len  = 3'd2;
         lead_bits = {16'd0, byte_in[4:0]};
      end else if (byte_in[7:4] == 4'b1110) begin
         lead_len  = 3'd3;
         lead_bits = {17'd0, byte_in[3:0]};
      end
      lead_has_res = 1'b1;
      lead_res     = '{last_result: 1'b1, byte_count: 3'd1, status: ST_OK,
                       code_point: {13'd0, byte_in}};
      if (byte_in[7]) begin
         if (byte_in[7:6] == 2'b10 || byte_in[7:3] == 5'b11111) begin
            lead_res.status     = ST_LEAD;
            lead_res.code_point = REPLACEMENT;
         end else if (end_of_buffer) begin
            lead_res.status     = ST_TRUNC;
            lead_res.code_point = REPLACEMENT;
         end else begin
            lead_has_res = 1'b0;
         end
      end
   end

   assign consumed = len_ff - {1'b0, rem_ff};
   assign acc_next = {acc_ff[CP_W-7:0], byte_in[5:0]};

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      len_in = len_ff;
      push   = 1'b0;
      entry  = '0;
      if (accept) begin
         if (rem_ff == 2'd0) begin
            if (lead_has_res) begin
               push        = 1'b1;
               entry.first = lead_res;
            end else begin
               acc_in = lead_bits;
               rem_in = lead_len[1:0] - 2'd1;
               len_in = lead_len;
            end
         end else if (end_of_buffer && rem_ff > 2'd1) begin
            push        = 1'b1;
            entry.first = '{last_result: 1'b1, byte_count: consumed + 3'd1,
                            status: ST_TRUNC, code_point: REPLACEMENT};
            acc_in = '0;
            rem_in = '0;
            len_in = '0;
         end else if (byte_in[7:6] != 2'b10) begin
            // Bad trail: report it, then reuse the same byte as a new lead.
            push        = 1'b1;
            entry.first = '{last_result: 1'b0, byte_count: consumed,
                            status: ST_TRAIL, code_point: REPLACEMENT};
            acc_in = '0;
            rem_in = '0;
            len_in = '0;
            if (lead_has_res) begin
               entry.two    = 1'b1;
               entry.second = lead_res;
            end else begin
               entry.first.last_result = 1'b1;
               acc_in = lead_bits;
               rem_in = lead_len[1:0] - 2'd1;
               len_in = lead_len;
            end
         end else begin
            acc_in = acc_next;
            rem_in = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               push = 1'b1;
               entry.first.last_result = 1'b1;
               entry.first.byte_count  = len_ff;
               if (scalar_ok(acc_next)) begin
                  entry.first.status     = ST_OK;
                  entry.first.code_point = acc_next;
               end else begin
                  entry.first.status     = ST_CP;
                  entry.first.code_point = REPLACEMENT;
               end
               acc_in = '0;
               len_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= '0;
         len_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
      end
   end

   `UTF8D_ASSERT(a_len_covers_rem, clock, reset, (rem_ff != 2'd0) |-> (len_ff > {1'b0, rem_ff}))
   `UTF8D_ASSERT(a_idle_len_zero, clock, reset, (rem_ff == 2'd0) |-> (len_ff == 3'd0))

endmodule

// File: sv/utf8d_queue.sv
// Short queue of per-byte result entries between front and back end.
module utf8d_queue
   import utf8d_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

`include "utf8_stream_decoder_assert.svh"

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   entry_type        slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UTF8D_ASSERT(a_no_push_full, clock, reset, full |-> !push)
   `UTF8D_ASSERT(a_no_pop_empty, clock, reset, !not_empty |-> !pop)

endmodule

// File: sv/utf8d_back.sv
// Back end: splits queue entries into single results behind an output register.
module utf8d_back
   import utf8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_result
);

`include "utf8_stream_decoder_assert.svh"

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       sec_valid_ff, sec_valid_in;
   result_type sec_ff, sec_in;
   logic       load;

   assign load = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      sec_valid_in = sec_valid_ff;
      sec_in       = sec_ff;
      pop          = 1'b0;
      if (load) begin
         if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = sec_ff;
            sec_valid_in = 1'b0;
         end else if (head_valid) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_in       = head.first;
            sec_valid_in = head.two;
            sec_in       = head.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   // A pending second result always sits behind a first one in the output register.
   `UTF8D_ASSERT(a_second_behind_first, clock, reset, sec_valid_ff |-> out_valid_ff)
   `UTF8D_ASSERT(a_second_is_last, clock, reset, sec_valid_ff |-> sec_ff.last_result)

endmodule

// File: sv/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte per transaction in, decoded code points out.
// The block takes one byte per clock cycle while the queue is not full and runs it
// through a sequence tracker; up to QueueDepth per-byte result groups wait in a
// queue, and an output register hands results out one per cycle while rsp_tready is
// high, so a byte that yields two results (bad trail byte followed by a lead that
// completes on its own) hands them out one after the other. A completing byte's
// result is stored in a queue slot, then in the output register, before rsp shows it.
// Errors give U+FFFD with a status (1 bad lead, 2 bad trail, 3 bad code point,
// 4 truncated by req_tlast); rsp_tlast marks the final result caused by a byte.
module utf8_stream_decoder
   import utf8d_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [20:0] code_point, [23:21] status, [26:24] byte_count
   output logic        rsp_tlast    // last_result
);

   logic       accept;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   logic       full;
   logic       not_empty;
   entry_type  head;
   result_type rsp_result;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   utf8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_in       (req_tdata),
      .end_of_buffer (req_tlast),
      .push          (push),
      .entry         (push_entry)
   );

   utf8d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   utf8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {5'd0, rsp_result.byte_count, rsp_result.status,
                       rsp_result.code_point};
   assign rsp_tlast = rsp_result.last_result;

endmodule
